// ===== rtl/point_transform_wrap_project_clip_macros.svh =====
// Assertion macros for the point transform top level.
// Expects clk_i and rst_ni to be visible where a macro is used.
`ifndef POINT_TRANSFORM_WRAP_PROJECT_CLIP_MACROS_SVH
`define POINT_TRANSFORM_WRAP_PROJECT_CLIP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PTWPC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PTWPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ptwpc_pkg.sv =====
// Shared widths and constants for the point transform pipeline.
// Used by ptwpc_wrap and point_transform_wrap_project_clip; no dependencies.
`default_nettype none

package ptwpc_pkg;

  localparam int IDX_W      = 10;
  localparam int POS_W      = 31;
  localparam int COEF_W     = 16;
  localparam int ROW_W      = 3 * COEF_W;
  localparam int OFF_W      = 32;
  localparam int SIZE_W     = 31;
  localparam int SCR_W      = 15;
  localparam int INVD_W     = 23;
  localparam int MAX_POINTS = 1024;

  localparam int PROD_W = COEF_W + POS_W + 1;
  localparam int ACC_W  = PROD_W + 2;
  localparam int FRAC_SH = 12;
  localparam int T_W    = 39;
  localparam int MAG_W  = 40;
  localparam int LOC_W  = 32;

  // Floor modulo: a few remainder steps per pipeline stage.
  localparam int WRAP_BPS    = 4;
  localparam int WRAP_STAGES = MAG_W / WRAP_BPS;
  localparam int WRAP_LAT    = WRAP_STAGES + 3;

  // Reciprocal: long division of 2^32 by the depth.
  localparam int RCP_STEPS  = 33;
  localparam int RCP_BPS    = 3;
  localparam int RCP_STAGES = RCP_STEPS / RCP_BPS;

  localparam int NEAR_Q16 = 655;
  localparam int FAR_Q16  = 6553600;
  localparam int PRJ_W    = LOC_W + INVD_W + 1;
  localparam int SCR_SH   = 18;

  // Pipeline positions of the valid line.
  localparam int POS_ACC   = 1;
  localparam int POS_WRAP  = POS_ACC + WRAP_LAT;
  localparam int POS_DEPTH = POS_WRAP + 1;
  localparam int POS_MUL   = POS_DEPTH + RCP_STAGES + 1;
  localparam int PIPE_DEPTH = POS_MUL + 2;

  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;
  localparam int RIDX_W = 3;

  localparam logic [RIDX_W-1:0] REG_ROW_X  = 3'd0;
  localparam logic [RIDX_W-1:0] REG_ROW_Y  = 3'd1;
  localparam logic [RIDX_W-1:0] REG_ROW_Z  = 3'd2;
  localparam logic [RIDX_W-1:0] REG_OFF_X  = 3'd3;
  localparam logic [RIDX_W-1:0] REG_OFF_Y  = 3'd4;
  localparam logic [RIDX_W-1:0] REG_OFF_Z  = 3'd5;
  localparam logic [RIDX_W-1:0] REG_WORLD  = 3'd6;

endpackage

`default_nettype wire

// ===== rtl/ptwpc_wrap.sv =====
// One coordinate of the toroidal wrap: truncation, offset, pipelined floor modulo.
// Depends on ptwpc_pkg.
`default_nettype none

module ptwpc_wrap (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [ptwpc_pkg::ACC_W-1:0]    acc_i,
  input  logic signed [ptwpc_pkg::OFF_W-1:0]    offset_i,
  input  logic        [ptwpc_pkg::SIZE_W-1:0]   size_i,
  output logic signed [ptwpc_pkg::LOC_W-1:0]    wrapped_o
);

  localparam int SW = ptwpc_pkg::SIZE_W;
  localparam int MW = ptwpc_pkg::MAG_W;
  localparam int NS = ptwpc_pkg::WRAP_STAGES;

  logic [SW-1:0] half;
  assign half = size_i >> 1;

  // Truncate toward zero by biasing negative sums before the arithmetic shift.
  logic signed [ptwpc_pkg::ACC_W-1:0] acc_rnd;
  logic signed [ptwpc_pkg::T_W-1:0]   t_d, t_q;
  assign acc_rnd = acc_i + $signed({{(ptwpc_pkg::ACC_W-ptwpc_pkg::FRAC_SH){1'b0}},
                                    {ptwpc_pkg::FRAC_SH{acc_i[ptwpc_pkg::ACC_W-1]}}});
  assign t_d = ptwpc_pkg::T_W'(acc_rnd >>> ptwpc_pkg::FRAC_SH) + ptwpc_pkg::T_W'(offset_i);

  logic signed [MW-1:0] a_val;
  logic                 neg_d;
  logic [MW-1:0]        mag_d;
  assign a_val = MW'(t_q) + $signed({{(MW-SW){1'b0}}, half});
  assign neg_d = a_val[MW-1];
  assign mag_d = neg_d ? MW'(-a_val) : MW'(a_val);

  logic          neg_q [NS+1];
  logic [SW-1:0] rem_q [NS+1];
  logic [MW-1:0] dvd_q [NS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q      <= t_d;
      neg_q[0] <= neg_d;
      rem_q[0] <= '0;
      dvd_q[0] <= mag_d;
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_div
    logic [SW-1:0] rem_d;
    logic [MW-1:0] dvd_d;

    always_comb begin
      logic [SW:0]   tr;
      logic [SW-1:0] r;
      logic [MW-1:0] dv;
      r  = rem_q[k-1];
      dv = dvd_q[k-1];
      for (int j = 0; j < ptwpc_pkg::WRAP_BPS; j++) begin
        tr = {r, dv[MW-1]};
        dv = dv << 1;
        if (tr >= {1'b0, size_i}) begin
          tr = tr - {1'b0, size_i};
        end
        r = tr[SW-1:0];
      end
      rem_d = r;
      dvd_d = dv;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[k] <= neg_q[k-1];
        rem_q[k] <= rem_d;
        dvd_q[k] <= dvd_d;
      end
    end
  end

  // Floor modulo: a nonzero remainder of a negative value folds back into [0, S).
  logic [SW-1:0]                    rem_fix;
  logic signed [ptwpc_pkg::LOC_W-1:0] out_d, out_q;
  assign rem_fix = (neg_q[NS] && (rem_q[NS] != '0)) ? size_i - rem_q[NS] : rem_q[NS];
  assign out_d   = (size_i == '0) ? '0 :
                   $signed({1'b0, rem_fix}) - $signed({1'b0, half});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign wrapped_o = out_q;

endmodule

`default_nettype wire

// ===== rtl/point_transform_wrap_project_clip.sv =====
// Top level of the particle point transform, wrap, projection and clip pipeline.
// Depends on ptwpc_pkg, ptwpc_wrap and point_transform_wrap_project_clip_macros.svh.
`default_nettype none

// The block takes one particle per clock while in_ready_o is high and runs it
// through a 29-stage pipeline (camera transform, toroidal floor modulo, reciprocal
// of depth, projection and clip) followed by an output register. The two long
// divisions, floor modulo by the world size and 2^32 over depth, are unrolled over
// stages a few bits each and set the depth. Particles that fail the depth or clip
// test leave no result. When the output is held, the pipeline keeps moving until a
// visible result reaches its last stage; only then does in_ready_o drop.
// Configuration must be written through the APB port only while no transaction is
// in flight; the block itself does not enforce this.
module point_transform_wrap_project_clip (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [ptwpc_pkg::IDX_W-1:0]          point_index_i,
  input  logic [ptwpc_pkg::POS_W-1:0]          pos_x_i,
  input  logic [ptwpc_pkg::POS_W-1:0]          pos_y_i,
  input  logic [ptwpc_pkg::POS_W-1:0]          pos_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [ptwpc_pkg::IDX_W-1:0]          visible_index_o,
  output logic signed [ptwpc_pkg::SCR_W-1:0]   screen_x_o,
  output logic signed [ptwpc_pkg::SCR_W-1:0]   screen_y_o,
  output logic [ptwpc_pkg::INVD_W-1:0]         inverse_depth_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ptwpc_pkg::ADDR_W-1:0]         paddr,
  input  logic [ptwpc_pkg::DATA_W-1:0]         pwdata,
  output logic [ptwpc_pkg::DATA_W-1:0]         prdata,
  output logic                                 pready
);

  localparam int ND = ptwpc_pkg::PIPE_DEPTH;
  localparam int NR = ptwpc_pkg::RCP_STAGES;
  localparam int ZW = ptwpc_pkg::INVD_W;

  // ---------------- Configuration registers ----------------
  logic [ptwpc_pkg::ROW_W-1:0]  coef_q [3];
  logic [ptwpc_pkg::OFF_W-1:0]  off_q  [3];
  logic [ptwpc_pkg::SIZE_W-1:0] size_q;
  logic [ptwpc_pkg::RIDX_W-1:0] reg_idx;
  logic                         cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ptwpc_pkg::ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= ptwpc_pkg::ROW_W'(48'h0000_0000_1000);
      coef_q[1] <= ptwpc_pkg::ROW_W'(48'h0000_1000_0000);
      coef_q[2] <= ptwpc_pkg::ROW_W'(48'h1000_0000_0000);
      off_q[0]  <= '0;
      off_q[1]  <= '0;
      off_q[2]  <= '0;
      size_q    <= ptwpc_pkg::SIZE_W'(524288);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        ptwpc_pkg::REG_ROW_X: coef_q[0] <= pwdata[ptwpc_pkg::ROW_W-1:0];
        ptwpc_pkg::REG_ROW_Y: coef_q[1] <= pwdata[ptwpc_pkg::ROW_W-1:0];
        ptwpc_pkg::REG_ROW_Z: coef_q[2] <= pwdata[ptwpc_pkg::ROW_W-1:0];
        ptwpc_pkg::REG_OFF_X: off_q[0]  <= pwdata[ptwpc_pkg::OFF_W-1:0];
        ptwpc_pkg::REG_OFF_Y: off_q[1]  <= pwdata[ptwpc_pkg::OFF_W-1:0];
        ptwpc_pkg::REG_OFF_Z: off_q[2]  <= pwdata[ptwpc_pkg::OFF_W-1:0];
        ptwpc_pkg::REG_WORLD: size_q    <= pwdata[ptwpc_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ptwpc_pkg::REG_ROW_X: prdata = ptwpc_pkg::DATA_W'(coef_q[0]);
      ptwpc_pkg::REG_ROW_Y: prdata = ptwpc_pkg::DATA_W'(coef_q[1]);
      ptwpc_pkg::REG_ROW_Z: prdata = ptwpc_pkg::DATA_W'(coef_q[2]);
      ptwpc_pkg::REG_OFF_X: prdata = ptwpc_pkg::DATA_W'(off_q[0]);
      ptwpc_pkg::REG_OFF_Y: prdata = ptwpc_pkg::DATA_W'(off_q[1]);
      ptwpc_pkg::REG_OFF_Z: prdata = ptwpc_pkg::DATA_W'(off_q[2]);
      ptwpc_pkg::REG_WORLD: prdata = ptwpc_pkg::DATA_W'(size_q);
      default:              prdata = '0;
    endcase
  end

  // ---------------- Pipeline control ----------------
  logic                         pipe_en;
  logic                         last_busy;
  logic                         vld_q [ND];
  logic [ptwpc_pkg::IDX_W-1:0]  idx_q [ND];
  logic                         vis_q;
  logic                         out_valid_q;

  assign last_busy  = vld_q[ND-1] && vis_q;
  assign pipe_en    = !last_busy || !out_valid_q || out_ready_i;
  assign in_ready_o = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ND; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (pipe_en) begin
      vld_q[0] <= in_valid_i &&
                  ({1'b0, point_index_i} < (ptwpc_pkg::IDX_W+1)'(ptwpc_pkg::MAX_POINTS));
      for (int i = 1; i < ND; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      idx_q[0] <= point_index_i;
      for (int i = 1; i < ND; i++) begin
        idx_q[i] <= idx_q[i-1];
      end
    end
  end

  // ---------------- Camera transform ----------------
  logic [ptwpc_pkg::POS_W-1:0]         pos [3];
  logic signed [ptwpc_pkg::PROD_W-1:0] prod_q [3][3];
  logic signed [ptwpc_pkg::ACC_W-1:0]  acc_q  [3];
  logic signed [ptwpc_pkg::LOC_W-1:0]  loc    [3];

  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= $signed(coef_q[r][c*ptwpc_pkg::COEF_W +: ptwpc_pkg::COEF_W]) *
                          $signed({1'b0, pos[c]});
        end
        acc_q[r] <= ptwpc_pkg::ACC_W'(prod_q[r][0]) + ptwpc_pkg::ACC_W'(prod_q[r][1]) +
                    ptwpc_pkg::ACC_W'(prod_q[r][2]);
      end
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_wrap
    ptwpc_wrap u_wrap (
      .clk_i     (clk_i),
      .en_i      (pipe_en),
      .acc_i     (acc_q[r]),
      .offset_i  ($signed(off_q[r])),
      .size_i    (size_q),
      .wrapped_o (loc[r])
    );
  end

  // ---------------- Depth test and reciprocal ----------------
  logic signed [ptwpc_pkg::LOC_W-1:0] rx_q  [NR+1];
  logic signed [ptwpc_pkg::LOC_W-1:0] ry_q  [NR+1];
  logic                               ok_q  [NR+1];
  logic [ZW-1:0]                      z_q   [NR+1];
  logic [ZW-1:0]                      rem_q [NR+1];
  logic [ZW-1:0]                      quo_q [NR+1];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      rx_q[0]  <= loc[0];
      ry_q[0]  <= loc[1];
      ok_q[0]  <= (loc[2] > ptwpc_pkg::LOC_W'(ptwpc_pkg::NEAR_Q16)) &&
                  (loc[2] < ptwpc_pkg::LOC_W'(ptwpc_pkg::FAR_Q16));
      z_q[0]   <= loc[2][ZW-1:0];
      rem_q[0] <= '0;
      quo_q[0] <= '0;
    end
  end

  // Dividend is 2^32: only the first step brings in a one.
  for (genvar k = 1; k <= NR; k++) begin : g_rcp
    logic [ZW-1:0] rem_d, quo_d;

    always_comb begin
      logic [ZW:0]   tr;
      logic [ZW-1:0] r;
      logic [ZW-1:0] q;
      r = rem_q[k-1];
      q = quo_q[k-1];
      for (int j = 0; j < ptwpc_pkg::RCP_BPS; j++) begin
        tr = {r, ((k - 1) * ptwpc_pkg::RCP_BPS + j) == 0};
        if (tr >= {1'b0, z_q[k-1]}) begin
          tr = tr - {1'b0, z_q[k-1]};
          q  = {q[ZW-2:0], 1'b1};
        end else begin
          q  = {q[ZW-2:0], 1'b0};
        end
        r = tr[ZW-1:0];
      end
      rem_d = r;
      quo_d = q;
    end

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        rx_q[k]  <= rx_q[k-1];
        ry_q[k]  <= ry_q[k-1];
        ok_q[k]  <= ok_q[k-1];
        z_q[k]   <= z_q[k-1];
        rem_q[k] <= rem_d;
        quo_q[k] <= quo_d;
      end
    end
  end

  // ---------------- Projection and clip ----------------
  logic signed [ptwpc_pkg::PRJ_W-1:0] px_q, py_q;
  logic                               okm_q;
  logic [ZW-1:0]                      wm_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      px_q  <= rx_q[NR] * $signed({1'b0, quo_q[NR]});
      py_q  <= ry_q[NR] * $signed({1'b0, quo_q[NR]});
      okm_q <= ok_q[NR];
      wm_q  <= quo_q[NR];
    end
  end

  localparam logic signed [ptwpc_pkg::PRJ_W-1:0] OneQ32 = ptwpc_pkg::PRJ_W'(64'h1_0000_0000);
  localparam logic signed [ptwpc_pkg::PRJ_W-1:0] RndQ   =
    ptwpc_pkg::PRJ_W'((64'd1 << ptwpc_pkg::SCR_SH) - 64'd1);

  logic                               clip_ok;
  logic signed [ptwpc_pkg::PRJ_W-1:0] px_rnd, py_rnd;
  logic signed [ptwpc_pkg::SCR_W-1:0] sx_q, sy_q;
  logic [ZW-1:0]                      wp_q;

  assign clip_ok = (px_q > -OneQ32) && (px_q < OneQ32) && (py_q > -OneQ32) && (py_q < OneQ32);
  assign px_rnd  = px_q + (px_q[ptwpc_pkg::PRJ_W-1] ? RndQ : '0);
  assign py_rnd  = py_q + (py_q[ptwpc_pkg::PRJ_W-1] ? RndQ : '0);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      vis_q <= okm_q && clip_ok;
      sx_q  <= ptwpc_pkg::SCR_W'(px_rnd >>> ptwpc_pkg::SCR_SH);
      sy_q  <= ptwpc_pkg::SCR_W'(py_rnd >>> ptwpc_pkg::SCR_SH);
      wp_q  <= wm_q;
    end
  end

  // ---------------- Output register ----------------
  logic                              out_load;
  logic [ptwpc_pkg::IDX_W-1:0]       oidx_q;
  logic signed [ptwpc_pkg::SCR_W-1:0] osx_q, osy_q;
  logic [ZW-1:0]                     ow_q;

  assign out_load = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= last_busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      oidx_q <= idx_q[ND-1];
      osx_q  <= sx_q;
      osy_q  <= sy_q;
      ow_q   <= wp_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign visible_index_o = oidx_q;
  assign screen_x_o      = osx_q;
  assign screen_y_o      = osy_q;
  assign inverse_depth_o = ow_q;

  // ---------------- Assertions ----------------
`include "point_transform_wrap_project_clip_macros.svh"

  `PTWPC_ASSERT_IMPL(a_scr_range, out_valid_o,
    (screen_x_o != 15'sh4000) && (screen_y_o != 15'sh4000), "screen value out of range")
  `PTWPC_ASSERT_IMPL(a_w_range, out_valid_o,
    (inverse_depth_o >= 23'd655) && (inverse_depth_o <= 23'd6547206),
    "inverse depth out of range")
  `PTWPC_ASSERT_NEXT(a_hold_stalls, last_busy && out_valid_o && !out_ready_i,
    out_valid_o && vld_q[ND-1], "held result was lost from the last stage")

endmodule

`default_nettype wire
